// File: design/mvhs_pkg.sv
// shared constants, types and aspect table for the mpeg2 video header scanner
`timescale 1ns / 1ps

package mvhs_pkg;

  // start code bytes
  localparam logic [23:0] START_PREFIX   = 24'h000001;
  localparam logic [7:0]  PICTURE_CODE   = 8'h00;
  localparam logic [7:0]  SEQUENCE_CODE  = 8'hB3;

  // bytes captured after a sequence code
  localparam logic [2:0]  SEQ_SEEN_BYTES = 3'd3;
  localparam logic [2:0]  SEQ_FULL_BYTES = 3'd4;

  // aspect ratio information codes
  localparam logic [3:0]  ASPECT_SQUARE  = 4'd1;
  localparam logic [3:0]  ASPECT_4_3     = 4'd2;
  localparam logic [3:0]  ASPECT_16_9    = 4'd3;
  localparam logic [3:0]  ASPECT_221_100 = 4'd4;

  // field widths
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned NUM_W  = 20;
  localparam int unsigned DEN_W  = 19;

  typedef logic [7:0] tab_num_t;
  typedef logic [6:0] tab_den_t;

  // sequence header fields handed to the aspect unit
  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [3:0]        aspect_code;
  } seq_fields_t;

  // pixel aspect numerator from the code
  function automatic tab_num_t aspect_num(input logic [3:0] code);
    tab_num_t n;
    unique case (code)
      ASPECT_SQUARE:  n = 8'd1;
      ASPECT_4_3:     n = 8'd4;
      ASPECT_16_9:    n = 8'd16;
      ASPECT_221_100: n = 8'd221;
      default:        n = 8'd0;
    endcase
    return n;
  endfunction

  // pixel aspect denominator from the code
  function automatic tab_den_t aspect_den(input logic [3:0] code);
    tab_den_t d;
    unique case (code)
      ASPECT_4_3:     d = 7'd3;
      ASPECT_16_9:    d = 7'd9;
      ASPECT_221_100: d = 7'd100;
      default:        d = 7'd1;
    endcase
    return d;
  endfunction

endpackage

// File: design/mvhs_aspect.sv
// pixel aspect products from the sequence header size and aspect code
`timescale 1ns / 1ps

module mvhs_aspect
  import mvhs_pkg::*;
(
  input  seq_fields_t        seq_i,
  output logic [NUM_W-1:0]   aspect_num_o,
  output logic [DEN_W-1:0]   aspect_den_o
);

  tab_num_t tab_num;
  tab_den_t tab_den;

  // table lookup
  assign tab_num = aspect_num(seq_i.aspect_code);
  assign tab_den = aspect_den(seq_i.aspect_code);

  // small constant-by-size products, exact at the output widths
  assign aspect_num_o = NUM_W'(tab_num) * NUM_W'(seq_i.frame_height);
  assign aspect_den_o = DEN_W'(tab_den) * DEN_W'(seq_i.frame_width);

endmodule

// File: design/mpeg2_video_header_scanner.sv
// top level: byte-wise picture and sequence header scanner for mpeg2 video buffers
//
//  channel | dir | tdata fields (lsb first)                                  | tlast
//  in_     | in  | data_byte[7:0]                                            | end_of_buffer
//  out_    | out | picture_found, coding_type, sequence_seen, size_valid,    | -
//          |     | frame_width, frame_height, aspect_code, aspect_numerator, |
//          |     | aspect_denominator, zero fill to 80 bits                  |
//
// one input word per cycle; scanning state updates in the cycle of acceptance
// the result word is registered and appears in the cycle after the last byte of a buffer
// in_tready drops only while a result waits in the output register and out_tready is low
// reset (rst_n low, synchronous) clears the scanning state and the output valid
`timescale 1ns / 1ps

module mpeg2_video_header_scanner
  import mvhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // picture_found[0], coding_type[3:1], sequence_seen[4],
                                  // size_valid[5], frame_width[17:6], frame_height[29:18],
                                  // aspect_code[33:30], aspect_numerator[53:34],
                                  // aspect_denominator[72:54], zero[79:73]
);

  typedef enum logic [1:0] {
    PIC_IDLE,
    PIC_WAIT_SKIP,
    PIC_WAIT_TYPE
  } pic_state_t;

  logic [23:0] hist_r,       hist_nxt;
  logic [1:0]  fill_r,       fill_nxt;
  pic_state_t  pic_state_r,  pic_state_nxt;
  logic        pic_locked_r, pic_locked_nxt;
  logic [2:0]  pic_type_r,   pic_type_nxt;
  logic [2:0]  seq_prog_r,   seq_prog_nxt;
  logic        seq_locked_r, seq_locked_nxt;
  logic [31:0] seq_bytes_r,  seq_bytes_nxt;
  logic        out_valid_r;
  logic [79:0] out_data_r,   out_data_nxt;

  logic              in_acc;
  logic              prefix;
  logic [7:0]        b;
  logic              seq_seen;
  logic              size_valid;
  seq_fields_t       seq_fields;
  logic [NUM_W-1:0]  asp_num;
  logic [DEN_W-1:0]  asp_den;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign prefix    = (fill_r == 2'd3) && (hist_r == START_PREFIX);

  // picture code tracker
  always_comb begin
    pic_state_nxt  = pic_state_r;
    pic_locked_nxt = pic_locked_r;
    pic_type_nxt   = pic_type_r;
    unique case (pic_state_r)
      PIC_WAIT_SKIP: pic_state_nxt = PIC_WAIT_TYPE;
      PIC_WAIT_TYPE: begin
        pic_type_nxt   = b[5:3];
        pic_locked_nxt = 1'b1;
        pic_state_nxt  = PIC_IDLE;
      end
      default: begin
        if (!pic_locked_r && prefix && b == PICTURE_CODE) begin
          pic_state_nxt = PIC_WAIT_SKIP;
        end
      end
    endcase
  end

  // sequence code tracker and header byte capture
  always_comb begin
    seq_prog_nxt   = seq_prog_r;
    seq_locked_nxt = seq_locked_r;
    seq_bytes_nxt  = seq_bytes_r;
    if (seq_locked_r) begin
      if (seq_prog_r < SEQ_FULL_BYTES) begin
        seq_bytes_nxt = {seq_bytes_r[23:0], b};
        seq_prog_nxt  = seq_prog_r + 3'd1;
      end
    end else if (prefix && b == SEQUENCE_CODE) begin
      seq_locked_nxt = 1'b1;
      seq_prog_nxt   = '0;
      seq_bytes_nxt  = '0;
    end
  end

  // byte history
  assign hist_nxt = {hist_r[15:0], b};
  assign fill_nxt = (fill_r == 2'd3) ? fill_r : fill_r + 2'd1;

  // result fields from the updated state
  assign seq_seen   = seq_locked_nxt && (seq_prog_nxt >= SEQ_SEEN_BYTES);
  assign size_valid = seq_locked_nxt && (seq_prog_nxt >= SEQ_FULL_BYTES);

  always_comb begin
    seq_fields = '0;
    if (size_valid) begin
      seq_fields.frame_width  = seq_bytes_nxt[31:20];
      seq_fields.frame_height = seq_bytes_nxt[19:8];
      seq_fields.aspect_code  = seq_bytes_nxt[7:4];
    end
  end

  mvhs_aspect u_aspect (
    .seq_i        (seq_fields),
    .aspect_num_o (asp_num),
    .aspect_den_o (asp_den)
  );

  // pack the result word
  always_comb begin
    out_data_nxt         = '0;
    out_data_nxt[0]      = pic_locked_nxt;
    out_data_nxt[3:1]    = pic_locked_nxt ? pic_type_nxt : 3'd0;
    out_data_nxt[4]      = seq_seen;
    out_data_nxt[5]      = size_valid;
    out_data_nxt[17:6]   = seq_fields.frame_width;
    out_data_nxt[29:18]  = seq_fields.frame_height;
    out_data_nxt[33:30]  = seq_fields.aspect_code;
    out_data_nxt[53:34]  = asp_num;
    out_data_nxt[72:54]  = asp_den;
  end

  // scanning state, cleared at reset and after the last byte of a buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      fill_r       <= '0;
      pic_state_r  <= PIC_IDLE;
      pic_locked_r <= 1'b0;
      pic_type_r   <= '0;
      seq_prog_r   <= '0;
      seq_locked_r <= 1'b0;
      seq_bytes_r  <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        hist_r       <= '0;
        fill_r       <= '0;
        pic_state_r  <= PIC_IDLE;
        pic_locked_r <= 1'b0;
        pic_type_r   <= '0;
        seq_prog_r   <= '0;
        seq_locked_r <= 1'b0;
        seq_bytes_r  <= '0;
      end else begin
        hist_r       <= hist_nxt;
        fill_r       <= fill_nxt;
        pic_state_r  <= pic_state_nxt;
        pic_locked_r <= pic_locked_nxt;
        pic_type_r   <= pic_type_nxt;
        seq_prog_r   <= seq_prog_nxt;
        seq_locked_r <= seq_locked_nxt;
        seq_bytes_r  <= seq_bytes_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a new result only follows an accepted last byte
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result word without a buffer end");

  // the buffer end clears the fill count, both locks and the picture tracker state
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (fill_r == 2'd0 && !pic_locked_r && !seq_locked_r
                              && pic_state_r == PIC_IDLE))
    else $error("scanning state not cleared at buffer end");

  // size fields imply the sequence header was seen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4])
    else $error("size valid without sequence seen");

  // no coding type without a captured picture header
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("coding type without picture header");

  // header capture never runs past four bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_prog_r <= SEQ_FULL_BYTES)
    else $error("sequence capture overran");

endmodule

// File: test/tb_top.sv
// self-checking testbench for the mpeg2 video header scanner
`timescale 1ns / 1ps

module tb_top
  import mvhs_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_WORDS   = 500;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned DRAIN_EVERY    = 25;
  localparam int          DIR_ROWS       = 26;

  // picture tracker steps
  localparam logic [1:0] PIC_IDLE = 2'd0;
  localparam logic [1:0] PIC_SKIP = 2'd1;
  localparam logic [1:0] PIC_TYPE = 2'd2;

  // directed row kinds: result from the scanner copy, or written out below
  localparam logic [1:0] FROM_SCAN  = 2'd0;
  localparam logic [1:0] KNOWN_FULL = 2'd1;
  localparam logic [1:0] KNOWN_CUT  = 2'd2;

  // result word as carried on out_tdata, msb first
  typedef struct packed {
    logic [6:0]        zero_fill;
    logic [DEN_W-1:0]  aspect_denominator;
    logic [NUM_W-1:0]  aspect_numerator;
    logic [3:0]        aspect_code;
    logic [SIZE_W-1:0] frame_height;
    logic [SIZE_W-1:0] frame_width;
    logic              size_valid;
    logic              sequence_seen;
    logic [2:0]        coding_type;
    logic              picture_found;
  } header_info_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] known;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  // scanner copy used for prediction
  logic [23:0] byte_hist;
  logic [1:0]  hist_fill;
  logic [1:0]  pic_step;
  logic        pic_lock;
  logic [2:0]  pic_type;
  logic [2:0]  seq_count;
  logic        seq_lock;
  logic [31:0] seq_word;

  header_info_t pending_headers [$];
  header_info_t known_info [1:2];
  logic [7:0]   buffer_bytes [$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  stall_left     = 0;
  logic         idle_on        = 1'b1;

  // sequence header with largest sizes, header with a picture code inside it,
  // sequence header cut before the aspect byte
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN}, '{8'h01, 1'b0, FROM_SCAN},
    '{8'hB3, 1'b0, FROM_SCAN}, '{8'hFF, 1'b0, FROM_SCAN}, '{8'hFF, 1'b0, FROM_SCAN},
    '{8'hFF, 1'b0, FROM_SCAN}, '{8'h40, 1'b1, KNOWN_FULL},
    '{8'h00, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN}, '{8'h01, 1'b0, FROM_SCAN},
    '{8'hB3, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN},
    '{8'h01, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN},
    '{8'h01, 1'b0, FROM_SCAN}, '{8'hB3, 1'b1, FROM_SCAN},
    '{8'h00, 1'b0, FROM_SCAN}, '{8'h00, 1'b0, FROM_SCAN}, '{8'h01, 1'b0, FROM_SCAN},
    '{8'hB3, 1'b0, FROM_SCAN}, '{8'h12, 1'b0, FROM_SCAN}, '{8'h34, 1'b0, FROM_SCAN},
    '{8'h56, 1'b1, KNOWN_CUT}
  };

  mpeg2_video_header_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [11:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  task automatic clear_scanner();
    byte_hist = '0;
    hist_fill = '0;
    pic_step  = PIC_IDLE;
    pic_lock  = 1'b0;
    pic_type  = '0;
    seq_count = '0;
    seq_lock  = 1'b0;
    seq_word  = '0;
  endtask

  // advance the scanner copy by one byte, queue the header info at buffer end
  task automatic scan_byte(input logic [7:0] b, input logic last, input logic [1:0] known);
    logic         prefix;
    int unsigned  tab_num;
    int unsigned  tab_den;
    int unsigned  num_full;
    int unsigned  den_full;
    header_info_t info;
    prefix = (hist_fill == 2'd3) && (byte_hist == START_PREFIX);

    // picture code: type sits in the second byte after the code
    case (pic_step)
      PIC_SKIP: pic_step = PIC_TYPE;
      PIC_TYPE: begin
        pic_type = b[5:3];
        pic_lock = 1'b1;
        pic_step = PIC_IDLE;
      end
      default: if (!pic_lock && prefix && b == PICTURE_CODE) pic_step = PIC_SKIP;
    endcase

    // sequence code: collect the four bytes that follow
    if (seq_lock) begin
      if (seq_count < SEQ_FULL_BYTES) begin
        seq_word  = {seq_word[23:0], b};
        seq_count = seq_count + 3'd1;
      end
    end else if (prefix && b == SEQUENCE_CODE) begin
      seq_lock  = 1'b1;
      seq_count = '0;
      seq_word  = '0;
    end

    byte_hist = {byte_hist[15:0], b};
    if (hist_fill != 2'd3) hist_fill = hist_fill + 2'd1;

    if (last) begin
      info = '0;
      info.picture_found = pic_lock;
      info.coding_type   = pic_lock ? pic_type : 3'd0;
      info.sequence_seen = seq_lock && (seq_count >= SEQ_SEEN_BYTES);
      if (seq_lock && seq_count >= SEQ_FULL_BYTES) begin
        info.size_valid   = 1'b1;
        info.frame_width  = seq_word[31:20];
        info.frame_height = seq_word[19:8];
        info.aspect_code  = seq_word[7:4];
        case (seq_word[7:4])
          ASPECT_SQUARE:  begin tab_num = 1;   tab_den = 1;   end
          ASPECT_4_3:     begin tab_num = 4;   tab_den = 3;   end
          ASPECT_16_9:    begin tab_num = 16;  tab_den = 9;   end
          ASPECT_221_100: begin tab_num = 221; tab_den = 100; end
          default:        begin tab_num = 0;   tab_den = 1;   end
        endcase
        num_full = tab_num * info.frame_height;
        den_full = tab_den * info.frame_width;
        info.aspect_numerator   = num_full[NUM_W-1:0];
        info.aspect_denominator = den_full[DEN_W-1:0];
      end
      pending_headers.push_back((known != FROM_SCAN) ? known_info[known] : info);
      clear_scanner();
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic check_info(input header_info_t got);
    header_info_t want;
    if (pending_headers.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t result word %h arrived with nothing expected", $time, got);
    end else begin
      want = pending_headers.pop_front();
      compare_field("picture_found", want.picture_found, got.picture_found);
      compare_field("coding_type", want.coding_type, got.coding_type);
      compare_field("sequence_seen", want.sequence_seen, got.sequence_seen);
      compare_field("size_valid", want.size_valid, got.size_valid);
      compare_field("frame_width", want.frame_width, got.frame_width);
      compare_field("frame_height", want.frame_height, got.frame_height);
      compare_field("aspect_code", want.aspect_code, got.aspect_code);
      compare_field("aspect_numerator", want.aspect_numerator, got.aspect_numerator);
      compare_field("aspect_denominator", want.aspect_denominator, got.aspect_denominator);
      compare_field("zero fill", want.zero_fill, got.zero_fill);
    end
  endtask

  // offer one byte, hold it until taken, then predict
  task automatic send_byte(input logic [7:0] data, input logic last, input logic [1:0] known);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    scan_byte(data, last, known);
  endtask

  // sender holds off until every queued result word has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
  endtask

  task automatic append_code(input logic [7:0] code);
    buffer_bytes.push_back(START_PREFIX[23:16]);
    buffer_bytes.push_back(START_PREFIX[15:8]);
    buffer_bytes.push_back(START_PREFIX[7:0]);
    buffer_bytes.push_back(code);
  endtask

  // one buffer: mostly header starts with random content, some noise,
  // some cut short so that headers run past the end
  task automatic build_buffer();
    int          cut;
    logic [11:0] w;
    logic [11:0] h;
    logic [3:0]  a;
    buffer_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0, 1: begin
            append_code(PICTURE_CODE);
            repeat (2) buffer_bytes.push_back(8'($urandom));
          end
          2, 3: begin
            w = pick_size();
            h = pick_size();
            a = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4)) : 4'($urandom);
            append_code(SEQUENCE_CODE);
            buffer_bytes.push_back(w[11:4]);
            buffer_bytes.push_back({w[3:0], h[11:8]});
            buffer_bytes.push_back(h[7:0]);
            buffer_bytes.push_back({a, 4'($urandom)});
          end
          default: begin
            repeat ($urandom_range(0, 3))
              case ($urandom_range(0, 2))
                0:       buffer_bytes.push_back(8'h00);
                1:       buffer_bytes.push_back(8'h01);
                default: buffer_bytes.push_back(8'($urandom));
              endcase
          end
        endcase
      end
      if (buffer_bytes.size() == 0) buffer_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, buffer_bytes.size());
        while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
      end
    end
  endtask

  // result side: random stalls, check every accepted word
  always @(posedge clk) begin
    int stall;
    if (rst_n && out_tvalid && out_tready) check_info(header_info_t'(out_tdata));
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall = pick_gap();
      stall_left <= (stall == 0) ? 0 : stall - 1;
      out_tready <= (stall == 0);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned buffers;
    clear_scanner();
    known_info[KNOWN_FULL] = '0;
    known_info[KNOWN_FULL].sequence_seen      = 1'b1;
    known_info[KNOWN_FULL].size_valid         = 1'b1;
    known_info[KNOWN_FULL].frame_width        = 12'hFFF;
    known_info[KNOWN_FULL].frame_height       = 12'hFFF;
    known_info[KNOWN_FULL].aspect_code        = ASPECT_221_100;
    known_info[KNOWN_FULL].aspect_numerator   = 20'd904995;
    known_info[KNOWN_FULL].aspect_denominator = 19'd409500;
    known_info[KNOWN_CUT] = '0;
    known_info[KNOWN_CUT].sequence_seen = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known);
    wait_for_results();

    sent    = 0;
    buffers = 0;
    while (sent < RANDOM_WORDS) begin
      build_buffer();
      idle_on = ($urandom_range(0, 3) != 0);
      foreach (buffer_bytes[i])
        send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1, FROM_SCAN);
      sent += buffer_bytes.size();
      buffers++;
      if (buffers % DRAIN_EVERY == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: mpeg2_video_header_scanner.f
design/mvhs_pkg.sv
design/mvhs_aspect.sv
design/mpeg2_video_header_scanner.sv
test/tb_top.sv
